// File: rtl/core/rgbab_pkg.sv
// Shared types and constants for the RGB555 alpha blend pixel block.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package rgbab_pkg;

    // Field widths fixed by the pixel format
    localparam int COLOR_W  = 16;
    localparam int ALPHA_W  = 8;
    localparam int SKIP_W   = 7;
    localparam int COPY_W   = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // Input word layout: src_color, src_alpha, dst_color from bit 0 up
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    // Bit 15 marks an opaque pixel
    localparam int OPAQUE_BIT = 15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COPY_THRESHOLD = 8'd1;

    // Reset values of the configuration registers
    localparam logic [SKIP_W-1:0] SKIP_RESET = 7'd8;
    localparam logic [COPY_W-1:0] COPY_RESET = 8'd128;

    typedef struct packed {
        logic [SKIP_W-1:0] skip_threshold;
        logic [COPY_W-1:0] copy_threshold;
    } cfg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] out_color;
        logic               write_enable;
    } blend_res_t;

endpackage

// File: rtl/core/rgbab_cfg_regs.sv
// Configuration register file: skip and copy thresholds.
// Depends on rgbab_pkg.
`timescale 1ns / 1ps

module rgbab_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rgbab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbab_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output rgbab_pkg::cfg_t                 cfg
);

    rgbab_pkg::cfg_t cfg_reg;
    rgbab_pkg::cfg_t cfg_next;

    // Always ready: every write is accepted and registered
    assign cfg_ready = 1'b1;

    // Decode the index; unknown indexes drop the write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                rgbab_pkg::CFG_SKIP_THRESHOLD: begin
                    cfg_next.skip_threshold = cfg_wdata[rgbab_pkg::SKIP_W-1:0];
                end
                rgbab_pkg::CFG_COPY_THRESHOLD: begin
                    cfg_next.copy_threshold = cfg_wdata[rgbab_pkg::COPY_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.skip_threshold <= rgbab_pkg::SKIP_RESET;
            cfg_reg.copy_threshold <= rgbab_pkg::COPY_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/rgbab_blend.sv
// Combinational blend datapath: decision logic and packed channel mix.
// Depends on rgbab_pkg.
`timescale 1ns / 1ps

module rgbab_blend #(
    parameter int ALPHA_BITS = 8
) (
    input  rgbab_pkg::cfg_t                  cfg,
    input  logic [rgbab_pkg::COLOR_W-1:0]    src_color,
    input  logic [rgbab_pkg::ALPHA_W-1:0]    src_alpha,
    input  logic [rgbab_pkg::COLOR_W-1:0]    dst_color,
    output rgbab_pkg::blend_res_t            res
);

    localparam int PROD_W = 32;
    localparam logic [8:0] MAX_ALPHA = 9'((1 << ALPHA_BITS) - 1);
    localparam logic signed [PROD_W-1:0] ALPHA_HALF = PROD_W'(1 << (ALPHA_BITS - 1));

    logic [20:0]              sbr;
    logic [20:0]              dbr;
    logic [9:0]               sg;
    logic [9:0]               dg;
    logic signed [21:0]       diff_br;
    logic signed [10:0]       diff_g;
    logic signed [PROD_W-1:0] alpha_ext;
    logic signed [PROD_W-1:0] prod_br;
    logic signed [PROD_W-1:0] prod_g;
    logic signed [PROD_W-1:0] mix_br;
    logic signed [PROD_W-1:0] mix_g;
    logic [15:0]              blend_color;
    logic                     pass_skip;
    logic                     in_window;
    logic                     do_copy;

    // Pack red at bits 0-4 and blue at bits 16-20; green stays at 5-9
    assign sbr = {src_color[14:10], 11'd0, src_color[4:0]};
    assign dbr = {dst_color[14:10], 11'd0, dst_color[4:0]};
    assign sg  = {src_color[9:5], 5'd0};
    assign dg  = {dst_color[9:5], 5'd0};

    assign diff_br = $signed({1'b0, sbr}) - $signed({1'b0, dbr});
    assign diff_g  = $signed({1'b0, sg}) - $signed({1'b0, dg});

    assign alpha_ext = $signed({{(PROD_W-rgbab_pkg::ALPHA_W){1'b0}}, src_alpha});

    // Scale the difference, round, floor-shift and add back the destination
    assign prod_br = PROD_W'(diff_br) * alpha_ext;
    assign prod_g  = PROD_W'(diff_g) * alpha_ext;

    assign mix_br = ((prod_br + ALPHA_HALF) >>> ALPHA_BITS)
                  + $signed({{(PROD_W-21){1'b0}}, dbr});
    assign mix_g  = ((prod_g + ALPHA_HALF) >>> ALPHA_BITS)
                  + $signed({{(PROD_W-10){1'b0}}, dg});

    // Unpack; carries between packed fields are kept as they fall
    assign blend_color = {1'b1, mix_br[20:16], mix_g[9:5], mix_br[4:0]};

    // Decisions: skip, blend window, copy
    assign pass_skip = src_alpha >= {1'b0, cfg.skip_threshold};
    assign in_window = dst_color[rgbab_pkg::OPAQUE_BIT]
                    && (({1'b0, src_alpha} + {2'b00, cfg.skip_threshold}) <= MAX_ALPHA);
    assign do_copy   = src_alpha >= cfg.copy_threshold;

    always_comb begin
        res.out_color    = dst_color;
        res.write_enable = 1'b0;
        if (pass_skip) begin
            if (in_window) begin
                res.out_color    = blend_color;
                res.write_enable = 1'b1;
            end else if (do_copy) begin
                res.out_color    = src_color;
                res.out_color[rgbab_pkg::OPAQUE_BIT] = 1'b1;
                res.write_enable = 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/rgb555_alpha_blend_pixel.sv
// RGB555 alpha blend pixel: top level with input and result registers.
// Path: input register, then one multiply, round and add, then result register.
// Throughput: one word per cycle while downstream is ready.
// Both stages hold under back-pressure; s_tready follows the downstream slot.
// Reset (aresetn low, synchronous) empties both stages and loads
// skip_threshold = 8, copy_threshold = 128. Depends on rgbab_pkg,
// rgbab_cfg_regs and rgbab_blend.
`timescale 1ns / 1ps

module rgb555_alpha_blend_pixel #(
    parameter int ALPHA_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // src_color [15:0], src_alpha [23:16], dst_color [39:24]
    input  logic [rgbab_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // out_color [15:0]
    output logic [rgbab_pkg::M_TDATA_W-1:0]    m_tdata,
    // write_enable [0]
    output logic                               m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rgbab_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgbab_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    rgbab_pkg::cfg_t       cfg;
    rgbab_pkg::blend_res_t res;

    logic                              in_valid_reg;
    logic                              in_valid_next;
    logic [rgbab_pkg::S_TDATA_W-1:0]   in_data_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    rgbab_pkg::blend_res_t             out_res_reg;
    logic                              out_load;
    logic                              in_load;

    rgbab_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rgbab_blend #(
        .ALPHA_BITS (ALPHA_BITS)
    ) u_blend (
        .cfg       (cfg),
        .src_color (in_data_reg[15:0]),
        .src_alpha (in_data_reg[23:16]),
        .dst_color (in_data_reg[39:24]),
        .res       (res)
    );

    // Result slot frees when empty or taken downstream
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    // Advance valid flags through both stages
    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_load) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_data_reg <= s_tdata;
        end
        if (out_load) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.out_color;
    assign m_tuser  = out_res_reg.write_enable;

endmodule

// File: rtl/core/rgbab_checker.sv
// Port-level checks for rgb555_alpha_blend_pixel, bound to the top level.
// Depends on rgbab_pkg and the top-level port list.
`timescale 1ns / 1ps

module rgbab_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [rgbab_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready
);

    // Reset empties the result stage
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // A stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // Every written pixel carries the opaque bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[rgbab_pkg::OPAQUE_BIT])
        else $error("written pixel without opaque bit");

    // An accepted word reaches the output via both stages when downstream is ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready ##1 m_tready |=> m_tvalid)
        else $error("accepted word did not reach the output");

endmodule

bind rgb555_alpha_blend_pixel rgbab_checker u_rgbab_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// File: verif/rgbab_blend_checker.sv
// Scoreboard for the RGB555 alpha blend pixel block: watches the input, result and
// register write channels, predicts each result and compares it field by field.
// Depends on rgbab_pkg.
`timescale 1ns / 1ps

module rgbab_blend_checker #(
    parameter int ALPHA_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [rgbab_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [rgbab_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                               m_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [rgbab_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgbab_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output int                                 pixels_in_flight,
    output int                                 mismatch_count
);

    import rgbab_pkg::*;

    localparam int MAX_ALPHA  = (1 << ALPHA_BITS) - 1;
    localparam int ALPHA_HALF = 1 << (ALPHA_BITS - 1);

    cfg_t       shadow_cfg;
    blend_res_t predicted_pixels[$];

    // One packed word: d + floor(((s - d) * a + half) / 2^ALPHA_BITS)
    function automatic longint mix_word(input longint s, input longint d, input longint a);
        return d + (((s - d) * a + ALPHA_HALF) >>> ALPHA_BITS);
    endfunction

    function automatic blend_res_t blend_pixel(input cfg_t regs,
                                               input logic [COLOR_W-1:0] src,
                                               input logic [ALPHA_W-1:0] alpha,
                                               input logic [COLOR_W-1:0] dst);
        blend_res_t  res;
        longint      a;
        longint      src_rb;
        longint      dst_rb;
        logic [63:0] rb_bits;
        logic [63:0] g_bits;
        a = longint'(alpha);
        res.out_color    = dst;
        res.write_enable = 1'b0;
        if (a >= longint'(regs.skip_threshold)) begin
            if (dst[OPAQUE_BIT] && a <= longint'(MAX_ALPHA) - longint'(regs.skip_threshold)) begin
                // red at bits 0-4, blue moved up to bits 16-20 of one word
                src_rb  = longint'({src[14:10], 11'd0, src[4:0]});
                dst_rb  = longint'({dst[14:10], 11'd0, dst[4:0]});
                rb_bits = mix_word(src_rb, dst_rb, a);
                g_bits  = mix_word(longint'({src[9:5], 5'd0}), longint'({dst[9:5], 5'd0}), a);
                res.out_color    = {1'b1, rb_bits[20:16], g_bits[9:5], rb_bits[4:0]};
                res.write_enable = 1'b1;
            end else if (a >= longint'(regs.copy_threshold)) begin
                res.out_color    = {1'b1, src[14:0]};
                res.write_enable = 1'b1;
            end
        end
        return res;
    endfunction

    // Check results, predict inputs, then track register writes
    always @(posedge aclk) begin : watch_channels
        blend_res_t want;
        if (!aresetn) begin
            shadow_cfg.skip_threshold = SKIP_RESET;
            shadow_cfg.copy_threshold = COPY_RESET;
            predicted_pixels.delete();
            mismatch_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_pixels.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual out_color=%h write_enable=%b",
                             $time, m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = predicted_pixels.pop_front();
                    if (m_tdata[COLOR_W-1:0] !== want.out_color) begin
                        $display("%0t: out_color mismatch, expected %h, actual %h",
                                 $time, want.out_color, m_tdata[COLOR_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.write_enable) begin
                        $display("%0t: write_enable mismatch, expected %b, actual %b",
                                 $time, want.write_enable, m_tuser);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predicted_pixels.push_back(blend_pixel(shadow_cfg,
                                                       s_tdata[0 +: COLOR_W],
                                                       s_tdata[COLOR_W +: ALPHA_W],
                                                       s_tdata[COLOR_W+ALPHA_W +: COLOR_W]));
            end
            // keep only the low bits; drop writes to unknown indexes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SKIP_THRESHOLD) begin
                    shadow_cfg.skip_threshold = cfg_wdata[SKIP_W-1:0];
                end else if (cfg_index == CFG_COPY_THRESHOLD) begin
                    shadow_cfg.copy_threshold = cfg_wdata[COPY_W-1:0];
                end
            end
        end
        pixels_in_flight = predicted_pixels.size();
    end

endmodule

// File: verif/tb_rgb555_alpha_blend_pixel.sv
// Testbench top for rgb555_alpha_blend_pixel: clock, reset, pixel and register
// stimulus, sink back-pressure and the verdict. Depends on rgbab_pkg,
// rgb555_alpha_blend_pixel and rgbab_blend_checker.
`timescale 1ns / 1ps

module tb_rgb555_alpha_blend_pixel;

    import rgbab_pkg::*;

    localparam int BLEND_ALPHA_BITS  = 8;
    localparam int NUM_PHASES        = 8;
    localparam int PIXELS_PER_PHASE  = 250;
    localparam int SINK_HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES     = 8;
    localparam int CYCLE_LIMIT       = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 8'd2;

    logic                      aclk;
    logic                      aresetn;
    logic [S_TDATA_W-1:0]      s_tdata;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [M_TDATA_W-1:0]      m_tdata;
    logic                      m_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_wdata;

    int   pixels_in_flight;
    int   mismatch_count;
    int   cycle_count = 0;
    int   cur_skip = int'(SKIP_RESET);
    int   cur_copy = int'(COPY_RESET);
    int   send_calm = 0;
    logic quiet = 1'b0;
    logic hold_request = 1'b0;

    rgb555_alpha_blend_pixel #(
        .ALPHA_BITS (BLEND_ALPHA_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rgbab_blend_checker #(
        .ALPHA_BITS (BLEND_ALPHA_BITS)
    ) u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tdata          (s_tdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .pixels_in_flight (pixels_in_flight),
        .mismatch_count   (mismatch_count)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sink: random stall bursts, calm stretches, and one long hold on request
    initial begin : sink_ready
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (calm_left > 0 || quiet) begin
                m_tready <= 1'b1;
                if (calm_left > 0) calm_left--;
            end else if ($urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 16) - 1;
                if ($urandom_range(0, 3) == 0) calm_left = $urandom_range(32, 96);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one word; return at the falling edge after it was taken
    task automatic send_pixel(input logic [COLOR_W-1:0] src, input logic [ALPHA_W-1:0] alpha,
                              input logic [COLOR_W-1:0] dst);
        if (send_calm > 0) begin
            send_calm--;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
            if ($urandom_range(0, 3) == 0) send_calm = $urandom_range(32, 96);
        end
        s_tdata  <= {dst, alpha, src};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain_pixels();
        s_tvalid <= 1'b0;
        while (pixels_in_flight != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_wdata <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        if (idx == CFG_SKIP_THRESHOLD) begin
            cur_skip = int'(data[SKIP_W-1:0]);
        end else if (idx == CFG_COPY_THRESHOLD) begin
            cur_copy = int'(data[COPY_W-1:0]);
        end
    endtask

    // Favor alphas next to the decision thresholds
    function automatic logic [ALPHA_W-1:0] pick_alpha();
        int a;
        case ($urandom_range(0, 7))
            0: a = cur_skip + int'($urandom_range(0, 2)) - 1;
            1: a = 255 - cur_skip + int'($urandom_range(0, 2)) - 1;
            2: a = cur_copy + int'($urandom_range(0, 2)) - 1;
            3: a = $urandom_range(0, 1) ? 255 : 0;
            default: a = $urandom_range(0, 255);
        endcase
        if (a < 0) a = 0;
        if (a > 255) a = 255;
        return a[ALPHA_W-1:0];
    endfunction

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] skip_data;
        logic [CFG_DATA_W-1:0] copy_data;
        aresetn   = 1'b0;
        s_tdata   = '0;
        s_tvalid  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset thresholds: skip, blend window edges, copy, leave
        send_pixel(16'h7FFF, 8'd0,   16'h1234);
        send_pixel(16'h7FFF, 8'd7,   16'hFFFF);
        send_pixel(16'h7FFF, 8'd8,   16'h8000);
        send_pixel(16'h7FFF, 8'd247, 16'h8000);
        send_pixel(16'h7FFF, 8'd248, 16'h8000);
        send_pixel(16'h0000, 8'd255, 16'hFFFF);
        send_pixel(16'h1234, 8'd128, 16'h7FFF);
        send_pixel(16'h1234, 8'd127, 16'h7FFF);
        send_pixel(16'h0000, 8'd128, 16'hFFFF);
        send_pixel(16'h7C00, 8'd200, 16'h801F);
        send_pixel(16'h001F, 8'd100, 16'hFC00);
        send_pixel(16'h0000, 8'd17,  16'h83E0);
        send_pixel(16'hFFFF, 8'd240, 16'h8000);
        send_pixel(16'h5555, 8'd64,  16'hAAAA);
        send_pixel(16'h2AAA, 8'd192, 16'hD555);
        send_pixel(16'hFFFF, 8'd255, 16'h0000);
        send_pixel(16'h8001, 8'd8,   16'h0001);

        // Lowest thresholds: every opaque pixel blends, every other one copies
        drain_pixels();
        cfg_write(CFG_SKIP_THRESHOLD, 8'h00);
        cfg_write(CFG_COPY_THRESHOLD, 8'h00);
        send_pixel(16'h0000, 8'd0,   16'hFFFF);
        send_pixel(16'h7ABC, 8'd255, 16'h8123);
        send_pixel(16'h4321, 8'd0,   16'h1234);

        // Highest thresholds through out-of-range values; unknown index ignored
        drain_pixels();
        cfg_write(CFG_SKIP_THRESHOLD, 8'hFF);
        cfg_write(CFG_COPY_THRESHOLD, 8'hFF);
        cfg_write(CFG_FIRST_UNUSED, 8'h00);
        send_pixel(16'h7FFF, 8'd126, 16'hFFFF);
        send_pixel(16'h7FFF, 8'd127, 16'h8000);
        send_pixel(16'h001F, 8'd128, 16'h8000);
        send_pixel(16'h7FFF, 8'd129, 16'h8000);
        send_pixel(16'h7FFF, 8'd255, 16'h0000);

        // Random phases, each with fresh thresholds
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_pixels();
            if (p == NUM_PHASES - 1) quiet = 1'b1;
            case ($urandom_range(0, 4))
                0: skip_data = 8'd0;
                1: skip_data = 8'd127;
                2: skip_data = 8'h80 | 8'($urandom_range(0, 127));
                default: skip_data = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 3))
                0: copy_data = 8'd0;
                1: copy_data = 8'd255;
                default: copy_data = 8'($urandom_range(0, 255));
            endcase
            cfg_write(CFG_SKIP_THRESHOLD, skip_data);
            if ($urandom_range(0, 2) == 0) begin
                cfg_write(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, 255)),
                          8'($urandom_range(0, 255)));
            end
            cfg_write(CFG_COPY_THRESHOLD, copy_data);
            // hold the sink off so the block fills and stalls its input
            if (p == 1) hold_request = 1'b1;
            for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
                // pause the source until the pipeline is empty
                if (p == 3 && i == PIXELS_PER_PHASE / 2) drain_pixels();
                send_pixel(16'($urandom()), pick_alpha(), 16'($urandom()));
            end
        end
        drain_pixels();

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/rgbab_pkg.sv
rtl/core/rgbab_cfg_regs.sv
rtl/core/rgbab_blend.sv
rtl/core/rgb555_alpha_blend_pixel.sv
rtl/core/rgbab_checker.sv
verif/rgbab_blend_checker.sv
verif/tb_rgb555_alpha_blend_pixel.sv
